/* design/rbj_pkg.sv */
// retry backoff jitter: shared types, constants and the xorshift function
// no dependencies; used by every other file of the block

package rbj_pkg;

    localparam int unsigned SEED_W     = 64;
    localparam int unsigned CFG_W      = 14;
    localparam int unsigned ATTEMPT_W  = 8;
    localparam int unsigned DELAY_W    = 13;
    localparam int unsigned BASE_W     = 13;
    localparam int unsigned DIVISOR_W  = 12;
    localparam int unsigned SHIFTED_W  = 18;
    localparam int unsigned SH_W       = 3;
    localparam int unsigned CNT_W      = $clog2(SEED_W);

    localparam logic [CNT_W-1:0]     DIV_LAST        = CNT_W'(SEED_W - 1);
    localparam logic [BASE_W-1:0]    STD_UNIT_MS     = BASE_W'(100);
    localparam logic [SH_W-1:0]      STD_SHIFT_MAX   = SH_W'(6);
    localparam logic [BASE_W-1:0]    STD_CAP_MS      = BASE_W'(5000);
    localparam logic [SH_W-1:0]      FAST_SHIFT_MAX  = SH_W'(4);
    localparam logic [SHIFTED_W-1:0] FAST_CAP_MS     = SHIFTED_W'(250);
    localparam logic [7:0]           FAST_CAP_MULT   = 8'd10;
    localparam logic [CFG_W-1:0]     FAST_BASE_KNEE  = CFG_W'(25);
    localparam logic [CFG_W-1:0]     FAST_BASE_LIMIT = CFG_W'(10000);
    localparam logic [CFG_W-1:0]     FAST_BASE_RESET = CFG_W'(25);
    localparam logic [SEED_W-1:0]    SEED_STD_INIT   = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [SEED_W-1:0]    SEED_FAST_INIT  = 64'h2545_f491_4f6c_dd1d;

    localparam logic MODE_STD  = 1'b0;
    localparam logic MODE_FAST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic store;
    } cmd_t;

    function automatic logic [SEED_W-1:0] xorshift_advance(input logic [SEED_W-1:0] s_in);
        logic [SEED_W-1:0] s;
        s = s_in;
        s = s ^ (s << 13);
        s = s ^ (s >> 7);
        s = s ^ (s << 17);
        return s;
    endfunction

endpackage

/* design/rbj_if.sv */
// retry backoff jitter: request, response and configuration channel interfaces
// depends on rbj_pkg for field widths

interface rbj_req_if;
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic [rbj_pkg::ATTEMPT_W-1:0]  attempt;

    modport source (output valid, output opcode, output attempt, input ready);
    modport sink   (input valid, input opcode, input attempt, output ready);
endinterface

interface rbj_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [rbj_pkg::DELAY_W-1:0]    delay_ms;

    modport source (output valid, output delay_ms, input ready);
    modport sink   (input valid, input delay_ms, output ready);
endinterface

interface rbj_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rbj_pkg::CFG_W-1:0]      data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/rbj_ctrl.sv */
// retry backoff jitter: controller state machine, step counter, result valid
// depends on rbj_pkg for state and command types

module rbj_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output rbj_pkg::cmd_t           cmd
);

    rbj_pkg::state_t               state_reg, state_next;
    logic [rbj_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == rbj_pkg::ST_IDLE);
    assign rsp_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rbj_pkg::ST_IDLE:
            begin
                if (req_valid)
                    state_next = rbj_pkg::ST_DIV;
            end
            rbj_pkg::ST_DIV:
            begin
                if (cnt_reg == rbj_pkg::DIV_LAST)
                    state_next = rbj_pkg::ST_DONE;
            end
            rbj_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = rbj_pkg::ST_IDLE;
            end
            default:
                state_next = rbj_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            rbj_pkg::ST_IDLE: cmd.load  = req_valid;
            rbj_pkg::ST_DIV:  cmd.step  = 1'b1;
            rbj_pkg::ST_DONE: cmd.store = out_free;
            default:          cmd       = '0;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
            cnt_next = '0;
        else if (cmd.step)
            cnt_next = cnt_reg + 1'b1;
        out_valid_next = cmd.store || (out_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbj_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == rbj_pkg::ST_DIV) && (cnt_reg == '0))
        else $error("load did not start the division");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rbj_pkg::ST_DIV) && (cnt_reg == rbj_pkg::DIV_LAST)
        |=> state_reg == rbj_pkg::ST_DONE)
        else $error("division did not end after the last step");

    a_store_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |=> out_valid_reg)
        else $error("stored result not presented");

    a_store_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !out_valid_reg || rsp_ready)
        else $error("result overwritten before taken");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.store}))
        else $error("more than one command at once");

endmodule

/* design/rbj_dp.sv */
// retry backoff jitter: base calculation, seed register, bit-serial modulo, result register
// depends on rbj_pkg for widths, constants and the xorshift function

module rbj_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  rbj_pkg::cmd_t                   cmd,
    input  logic                            opcode,
    input  logic [rbj_pkg::ATTEMPT_W-1:0]   attempt,
    input  logic                            cfg_we,
    input  logic [rbj_pkg::CFG_W-1:0]       cfg_data,
    output logic [rbj_pkg::DELAY_W-1:0]     delay_ms
);

    logic [rbj_pkg::CFG_W-1:0]      fast_base_reg;
    logic [rbj_pkg::SEED_W-1:0]     seed_reg;
    logic [rbj_pkg::SEED_W-1:0]     dividend_reg;
    logic [rbj_pkg::DIVISOR_W-1:0]  rem_reg;
    logic [rbj_pkg::DIVISOR_W-1:0]  divisor_reg;
    logic [rbj_pkg::BASE_W-1:0]     base_reg;
    logic [rbj_pkg::DELAY_W-1:0]    delay_reg;

    logic [rbj_pkg::SH_W-1:0]       std_sh, fast_sh;
    logic [rbj_pkg::BASE_W-1:0]     std_shifted, std_base;
    logic [rbj_pkg::CFG_W-1:0]      fast_b;
    logic [rbj_pkg::SHIFTED_W-1:0]  fast_shifted, fast_cap, fast_base;
    logic [rbj_pkg::BASE_W-1:0]     base_next;
    logic [rbj_pkg::SEED_W-1:0]     seed_start, seed_next;
    logic [rbj_pkg::DIVISOR_W:0]    trial;
    logic [rbj_pkg::DIVISOR_W-1:0]  rem_next;

    // standard mode base
    always_comb
    begin
        std_sh      = (attempt > 8'(rbj_pkg::STD_SHIFT_MAX)) ? rbj_pkg::STD_SHIFT_MAX
                                                             : attempt[rbj_pkg::SH_W-1:0];
        std_shifted = rbj_pkg::STD_UNIT_MS << std_sh;
        std_base    = (std_shifted > rbj_pkg::STD_CAP_MS) ? rbj_pkg::STD_CAP_MS : std_shifted;
    end

    // fast mode base
    always_comb
    begin
        fast_b       = (fast_base_reg > rbj_pkg::FAST_BASE_LIMIT) ? rbj_pkg::FAST_BASE_LIMIT
                                                                  : fast_base_reg;
        fast_sh      = (attempt > 8'(rbj_pkg::FAST_SHIFT_MAX)) ? rbj_pkg::FAST_SHIFT_MAX
                                                               : attempt[rbj_pkg::SH_W-1:0];
        fast_shifted = {4'b0, fast_b} << fast_sh;
        if (fast_b >= rbj_pkg::FAST_BASE_KNEE)
            fast_cap = rbj_pkg::FAST_CAP_MS;
        else
            fast_cap = {10'b0, 8'({3'b0, fast_b[4:0]} * rbj_pkg::FAST_CAP_MULT)};
        fast_base    = (fast_shifted > fast_cap) ? fast_cap : fast_shifted;
    end

    always_comb
    begin
        base_next  = (opcode == rbj_pkg::MODE_FAST) ? fast_base[rbj_pkg::BASE_W-1:0] : std_base;
        seed_start = seed_reg;
        if (seed_reg == '0)
            seed_start = (opcode == rbj_pkg::MODE_FAST) ? rbj_pkg::SEED_FAST_INIT
                                                        : rbj_pkg::SEED_STD_INIT;
        seed_next  = rbj_pkg::xorshift_advance(seed_start);
    end

    // one restoring step of the modulo
    always_comb
    begin
        trial    = {rem_reg, dividend_reg[rbj_pkg::SEED_W-1]};
        rem_next = trial[rbj_pkg::DIVISOR_W-1:0];
        if (trial >= {1'b0, divisor_reg})
            rem_next = rbj_pkg::DIVISOR_W'(trial - {1'b0, divisor_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_base_reg <= rbj_pkg::FAST_BASE_RESET;
            seed_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                fast_base_reg <= cfg_data;
            if (cmd.load)
                seed_reg <= seed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dividend_reg <= seed_next;
            rem_reg      <= '0;
            base_reg     <= base_next;
            divisor_reg  <= base_next[rbj_pkg::BASE_W-1:1] + 1'b1;
        end
        else if (cmd.step)
        begin
            dividend_reg <= dividend_reg << 1;
            rem_reg      <= rem_next;
        end
        if (cmd.store)
            delay_reg <= base_reg + {1'b0, rem_reg};
    end

    assign delay_ms = delay_reg;

endmodule

/* design/retry_backoff_jitter_top.sv */
// retry backoff jitter: top level joining controller and datapath to the channels
// depends on rbj_pkg, rbj_if, rbj_ctrl and rbj_dp
//
// usage:
//   req carries one beat per retry: opcode (0 standard, 1 fast) and attempt
//   rsp returns one beat per request: delay_ms, capped base plus jitter
//   cfg writes fast_base_ms; it is always ready and is meant to be used
//   only while no request is in flight
// timing:
//   a request is taken while req.ready is high; the jitter modulo then runs
//   one bit of the 64-bit seed per cycle, the block then passes to its done
//   state and the result enters the output register once that is free, so
//   rsp.valid is set and req.ready goes high again in the same cycle
//   a new request is taken only once the previous result has been stored
// reset:
//   clears the seed to zero, sets fast_base_ms to 25 and empties the block
// stall:
//   a waiting result holds in the output register while the next request is
//   taken and worked on; if that one finishes first it waits for the output
//   register to drain and req.ready stays low until then

module retry_backoff_jitter_top
(
    input  logic        clk,
    input  logic        rst_n,
    rbj_req_if.sink     req,
    rbj_rsp_if.source   rsp,
    rbj_cfg_if.sink     cfg
);

    rbj_pkg::cmd_t cmd;

    assign cfg.ready = 1'b1;

    rbj_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    rbj_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .opcode   (req.opcode),
        .attempt  (req.attempt),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.data),
        .delay_ms (rsp.delay_ms)
    );

endmodule
